### src/dlc_pkg.sv
// Shared types, constants and register codes for the depth grid line classifier.
// Depends on nothing; every other file of the block imports it.
package dlc_pkg;

	// Geometry of the grid.
	localparam int ROW_WIDTH  = 8;
	localparam int ROW_COUNT  = 8;
	localparam int NUM_PIX_IN = 8;
	localparam int STORE_N    = ROW_COUNT - 1;

	// Field widths.
	localparam int PIX_W   = 16;
	localparam int ROW_W   = 3;
	localparam int CLS_W   = 2;
	localparam int RUN_W   = 4;
	localparam int HOLD_W  = 10;
	localparam int TOTAL_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Vote tally width, wide enough to hold STORE_N.
	localparam int VCNT_W = $clog2(ROW_COUNT);

	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [CLS_W-1:0]   cls_t;
	typedef logic [TOTAL_W-1:0] total_t;

	// Class codes.
	localparam cls_t CLS_EMPTY  = 2'd0;
	localparam cls_t CLS_SINGLE = 2'd1;
	localparam cls_t CLS_DOUBLE = 2'd2;
	localparam cls_t CLS_NONE   = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_VOTES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_HOLD    = 3'd4;

	typedef struct packed {
		logic [15:0]       dark_threshold;
		logic [3:0]        gap_min;
		logic [2:0]        double_votes;
		logic [RUN_W-1:0]  stable_count;
		logic [HOLD_W-1:0] single_hold;
	} cfg_t;

	// One row after the lane compare stage.
	typedef struct packed {
		logic [ROW_WIDTH-1:0] dark;
		row_t                 row_index;
		logic                 sensor_active;
	} row_item_t;

	// One frame result word.
	typedef struct packed {
		cls_t   frame_class;
		cls_t   confirmed_class;
		logic   stop_flag;
		total_t empty_total;
		total_t single_total;
		total_t double_total;
	} result_t;

endpackage

### src/dlc_lane.sv
// One pixel lane: compares a depth value against the dark threshold.
// Depends on dlc_pkg.
module dlc_lane (
	input  dlc_pkg::pix_t pixel,
	input  dlc_pkg::pix_t dark_threshold,
	output logic          dark
);
	import dlc_pkg::*;

	assign dark = (pixel <= dark_threshold);

endmodule

### src/dlc_row_merge.sv
// Merges the dark bits of all lanes into a row class (empty, single or double).
// Depends on dlc_pkg.
module dlc_row_merge (
	input  logic [dlc_pkg::ROW_WIDTH-1:0] dark,
	input  logic [3:0]                    gap_min,
	output dlc_pkg::cls_t                 row_class
);
	import dlc_pkg::*;

	localparam int GAP_W  = $clog2(ROW_WIDTH + 1);
	localparam int GCMP_W = (GAP_W > 4) ? GAP_W : 4;

	logic             seen, gap_ok, any_dark, dbl;
	logic [GAP_W-1:0] gap;

	// A double row needs a light run of at least gap_min pixels (and at least
	// one) with dark pixels on both sides of it.
	always_comb begin
		seen     = 1'b0;
		gap_ok   = 1'b0;
		any_dark = 1'b0;
		dbl      = 1'b0;
		gap      = '0;
		for (int c = 0; c < ROW_WIDTH; c++) begin
			if (dark[c]) begin
				if (seen && gap_ok)
					dbl = 1'b1;
				any_dark = 1'b1;
				seen     = 1'b1;
				gap      = '0;
			end else if (seen) begin
				gap = gap + GAP_W'(1);
				if (GCMP_W'(gap) >= GCMP_W'(gap_min))
					gap_ok = 1'b1;
			end
		end
		if (dbl)
			row_class = CLS_DOUBLE;
		else if (any_dark)
			row_class = CLS_SINGLE;
		else
			row_class = CLS_EMPTY;
	end

endmodule

### src/dlc_frame.sv
// Row class store, frame vote, debounce, single-line hold timer and event counters.
// Depends on dlc_pkg.
module dlc_frame (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  dlc_pkg::row_t    row_index,
	input  logic             sensor_active,
	input  dlc_pkg::cls_t    row_class,
	input  dlc_pkg::cfg_t    cfg,
	output logic             result_en,
	output dlc_pkg::result_t result
);
	import dlc_pkg::*;

	localparam int VCMP_W = (VCNT_W > 3) ? VCNT_W : 3;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	cls_t              store_q [STORE_N];
	cls_t              cand_q, conf_q, cand_d, conf_d, vote_cls, fc;
	logic [RUN_W-1:0]  run_q, run_d;
	logic              hold_q, hold_d, stop_q, stop_d;
	logic [HOLD_W-1:0] timer_q, timer_d;
	total_t            empty_q, single_q, double_q, empty_d, single_d, double_d;
	logic [VCNT_W-1:0] n1, n2;
	logic              is_frame;

	assign is_frame  = (32'(row_index) == 32'(STORE_N));
	assign result_en = go && is_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < STORE_N; r++)
				store_q[r] <= CLS_SINGLE;
		end else if (go) begin
			for (int r = 0; r < STORE_N; r++)
				if (32'(row_index) == 32'(r))
					store_q[r] <= row_class;
		end
	end

	// Tally of the stored row classes.
	always_comb begin
		n1 = '0;
		n2 = '0;
		for (int r = 0; r < STORE_N; r++) begin
			if (store_q[r] == CLS_DOUBLE)
				n2 = n2 + VCNT_W'(1);
			else if (store_q[r] == CLS_SINGLE)
				n1 = n1 + VCNT_W'(1);
		end
		if (VCMP_W'(n2) >= VCMP_W'(cfg.double_votes))
			vote_cls = CLS_DOUBLE;
		else if ((n1 != '0) || (n2 != '0))
			vote_cls = CLS_SINGLE;
		else
			vote_cls = CLS_EMPTY;
	end

	always_comb begin
		cand_d   = cand_q;
		run_d    = run_q;
		conf_d   = conf_q;
		hold_d   = hold_q;
		timer_d  = timer_q;
		stop_d   = stop_q;
		empty_d  = empty_q;
		single_d = single_q;
		double_d = double_q;
		if (!sensor_active) begin
			cand_d = CLS_NONE;
			conf_d = CLS_NONE;
			run_d  = '0;
			hold_d = 1'b0;
			fc     = CLS_NONE;
		end else begin
			fc = vote_cls;
			if (fc == cand_q) begin
				if (run_q != RUN_MAX)
					run_d = run_q + RUN_W'(1);
			end else begin
				cand_d = fc;
				run_d  = RUN_W'(1);
			end
			if ((run_d >= cfg.stable_count) && (cand_d != conf_q)) begin
				case (cand_d)
					CLS_SINGLE: begin
						hold_d  = 1'b1;
						timer_d = '0;
						conf_d  = CLS_SINGLE;
					end
					CLS_DOUBLE: begin
						hold_d   = 1'b0;
						conf_d   = CLS_DOUBLE;
						double_d = double_q + TOTAL_W'(1);
						stop_d   = 1'b1;
					end
					default: begin
						if (hold_q) begin
							hold_d   = 1'b0;
							single_d = single_q + TOTAL_W'(1);
						end
						conf_d  = CLS_EMPTY;
						empty_d = empty_q + TOTAL_W'(1);
						stop_d  = 1'b0;
					end
				endcase
			end
			if (hold_d) begin
				timer_d = timer_d + HOLD_W'(1);
				if (timer_d >= cfg.single_hold) begin
					hold_d   = 1'b0;
					single_d = single_d + TOTAL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= CLS_NONE;
			run_q    <= '0;
			conf_q   <= CLS_NONE;
			hold_q   <= 1'b0;
			timer_q  <= '0;
			stop_q   <= 1'b0;
			empty_q  <= '0;
			single_q <= '0;
			double_q <= '0;
		end else if (result_en) begin
			cand_q   <= cand_d;
			run_q    <= run_d;
			conf_q   <= conf_d;
			hold_q   <= hold_d;
			timer_q  <= timer_d;
			stop_q   <= stop_d;
			empty_q  <= empty_d;
			single_q <= single_d;
			double_q <= double_d;
		end
	end

	always_comb begin
		result.frame_class     = fc;
		result.confirmed_class = conf_d;
		result.stop_flag       = stop_d;
		result.empty_total     = empty_d;
		result.single_total    = single_d;
		result.double_total    = double_d;
	end

endmodule

### src/depth_grid_line_classifier.sv
// Top level of the depth grid line classifier: lanes, row merge, frame logic, ports.
// Depends on dlc_pkg, dlc_lane, dlc_row_merge and dlc_frame.
//
// The block takes one row of eight depth pixels per word and can accept a
// new word in every clock cycle. Rows 0 to 6 are classified and stored and
// give no result; row 7 closes the frame and gives exactly one result word.
// On the way from the accepted input word to the result word, the eight
// threshold compare lanes run in parallel and their dark bits are registered
// in stage 1; the row merge then turns these into a row class and, for the
// last row, the frame logic votes the stored classes, updates the debounce,
// the hold timer and the counters, and loads the output register. The output
// register decouples the two sides, so input words keep flowing while a
// result waits; only a frame-closing row waits for the output register to be
// free. Configuration registers are written through cfg_we, cfg_index and
// cfg_data and should only change while no word is in flight.
module depth_grid_line_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dlc_pkg::row_t                   row_index,
	input  dlc_pkg::pix_t                   pixel_0,
	input  dlc_pkg::pix_t                   pixel_1,
	input  dlc_pkg::pix_t                   pixel_2,
	input  dlc_pkg::pix_t                   pixel_3,
	input  dlc_pkg::pix_t                   pixel_4,
	input  dlc_pkg::pix_t                   pixel_5,
	input  dlc_pkg::pix_t                   pixel_6,
	input  dlc_pkg::pix_t                   pixel_7,
	input  logic                            sensor_active,
	output logic                            out_valid,
	input  logic                            out_ready,
	output dlc_pkg::cls_t                   frame_class,
	output dlc_pkg::cls_t                   confirmed_class,
	output logic                            stop_flag,
	output dlc_pkg::total_t                 empty_total,
	output dlc_pkg::total_t                 single_total,
	output dlc_pkg::total_t                 double_total,
	input  logic                            cfg_we,
	input  logic [dlc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dlc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dlc_pkg::*;

	cfg_t                 cfg_q;
	pix_t                 pix [NUM_PIX_IN];
	logic [ROW_WIDTH-1:0] dark;
	row_item_t            item_s1;
	logic                 valid_s1;
	logic                 frame_s1, out_free, go;
	cls_t                 row_class;
	logic                 result_en;
	result_t              result, out_q;
	logic                 out_valid_q;

	// Configuration registers, to be written only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold <= 16'd127;
			cfg_q.gap_min        <= 4'd3;
			cfg_q.double_votes   <= 3'd3;
			cfg_q.stable_count   <= RUN_W'(3);
			cfg_q.single_hold    <= HOLD_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data;
				REG_GAP_MIN:        cfg_q.gap_min        <= cfg_data[3:0];
				REG_DOUBLE_VOTES:   cfg_q.double_votes   <= cfg_data[2:0];
				REG_STABLE_COUNT:   cfg_q.stable_count   <= cfg_data[RUN_W-1:0];
				REG_SINGLE_HOLD:    cfg_q.single_hold    <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign pix[0] = pixel_0;
	assign pix[1] = pixel_1;
	assign pix[2] = pixel_2;
	assign pix[3] = pixel_3;
	assign pix[4] = pixel_4;
	assign pix[5] = pixel_5;
	assign pix[6] = pixel_6;
	assign pix[7] = pixel_7;

	// One compare lane per column. Columns past the input pixels are set
	// straight to dark.
	for (genvar c = 0; c < ROW_WIDTH; c++) begin : g_lane
		if (c < NUM_PIX_IN) begin : g_pix
			dlc_lane u_lane (
				.pixel          (pix[c]),
				.dark_threshold (cfg_q.dark_threshold),
				.dark           (dark[c])
			);
		end else begin : g_zero
			assign dark[c] = 1'b1;
		end
	end

	// Stage 1 holds the dark bits of one row. Rows that produce no result
	// always move on; a frame-closing row moves on only when the output
	// register is free or being emptied.
	assign frame_s1 = (32'(item_s1.row_index) == 32'(STORE_N));
	assign out_free = !out_valid_q || out_ready;
	assign go       = valid_s1 && (!frame_s1 || out_free);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.dark          <= dark;
			item_s1.row_index     <= row_index;
			item_s1.sensor_active <= sensor_active;
		end
	end

	dlc_row_merge u_merge (
		.dark      (item_s1.dark),
		.gap_min   (cfg_q.gap_min),
		.row_class (row_class)
	);

	dlc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.row_index     (item_s1.row_index),
		.sensor_active (item_s1.sensor_active),
		.row_class     (row_class),
		.cfg           (cfg_q),
		.result_en     (result_en),
		.result        (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (result_en)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (result_en)
			out_q <= result;
	end

	assign out_valid       = out_valid_q;
	assign frame_class     = out_q.frame_class;
	assign confirmed_class = out_q.confirmed_class;
	assign stop_flag       = out_q.stop_flag;
	assign empty_total     = out_q.empty_total;
	assign single_total    = out_q.single_total;
	assign double_total    = out_q.double_total;

endmodule

### src/dlc_checker.sv
// Port-level assertions for the depth grid line classifier, bound to the top level.
// Depends on dlc_pkg and depth_grid_line_classifier.
module dlc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input dlc_pkg::cls_t   frame_class,
	input dlc_pkg::cls_t   confirmed_class,
	input logic            stop_flag,
	input dlc_pkg::total_t empty_total,
	input dlc_pkg::total_t single_total,
	input dlc_pkg::total_t double_total
);
	import dlc_pkg::*;

	// A result word that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_class)
			&& $stable(confirmed_class) && $stable(stop_flag) && $stable(empty_total)
			&& $stable(single_total) && $stable(double_total))
		else $error("stalled result word changed");

	// An inactive frame always leaves the debounce with nothing confirmed.
	a_inactive_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_class == CLS_NONE) |-> (confirmed_class == CLS_NONE))
		else $error("inactive frame left a confirmed class");

	// The stop flag follows the last confirmed double or empty class.
	a_stop_double: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (confirmed_class == CLS_DOUBLE) |-> stop_flag)
		else $error("confirmed double without stop flag");

	a_stop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (confirmed_class == CLS_EMPTY) |-> !stop_flag)
		else $error("confirmed empty with stop flag set");

endmodule

bind depth_grid_line_classifier dlc_checker u_dlc_checker (.*);
